// ===== hdl/lce_pkg.sv =====
`default_nettype none
package lce_pkg;

    localparam int PHASE_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int ELAPSED_W  = 32;
    localparam int MOD_CELLS  = ELAPSED_W;
    localparam int NUM_CELLS  = MOD_CELLS + FRAC_BITS;
    localparam int ENV_DEPTH  = (1 << (PHASE_BITS - 1)) + 1;
    localparam int ENV_AW     = PHASE_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_A       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_B       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_DURATION = 3'd6;

    localparam logic [2:0] MODE_SOLID   = 3'd0;
    localparam logic [2:0] MODE_FADE    = 3'd1;
    localparam logic [2:0] MODE_BREATHE = 3'd2;
    localparam logic [2:0] MODE_STROBE  = 3'd3;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam int unsigned SIN_DIV [7] = '{210, 156, 110, 72, 42, 20, 6};

    typedef struct packed {
        logic                  valid;
        logic [ELAPSED_W-1:0]  e;
        logic [ELAPSED_W-1:0]  rem;
        logic [FRAC_BITS-1:0]  quo;
        logic                  strobe_on;
    } cell_t;

    typedef logic [FRAC_BITS:0] env_tab_t [ENV_DEPTH];

    function automatic logic [FRAC_BITS:0] env_value(input int unsigned kk);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] env;
        x = (64'(kk) * PI_Q30) >> PHASE_BITS;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        for (int i = 0; i < 7; i++)
        begin
            t = ONE_Q30 - (((x2 * t) >> 30) / 64'(SIN_DIV[i]));
        end
        s = (x * t) >> 30;
        env = (s * s + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
        if (env > (64'd1 << FRAC_BITS))
        begin
            env = 64'd1 << FRAC_BITS;
        end
        return env[FRAC_BITS:0];
    endfunction

    function automatic env_tab_t env_table();
        env_tab_t tab;
        for (int i = 0; i < ENV_DEPTH; i++)
        begin
            tab[i] = env_value(i);
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/lce_if.sv =====
`default_nettype none
interface lce_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_ms;
    modport source (output valid, output elapsed_ms, input ready);
    modport sink (input valid, input elapsed_ms, output ready);
endinterface

interface lce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ===== hdl/lce_cell.sv =====
`default_nettype none
module lce_cell
    import lce_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire cell_t                din,
    input  wire logic [ELAPSED_W-1:0] divisor,
    input  wire logic                 shift_bit,
    output cell_t                     dout
);

    cell_t              cell_reg;
    cell_t              cell_next;
    logic [ELAPSED_W:0] trial;
    logic               fits;

    always_comb
    begin
        trial = {din.rem, shift_bit};
        fits = trial >= {1'b0, divisor};
        cell_next = din;
        cell_next.rem = fits ? ELAPSED_W'(trial - {1'b0, divisor}) : trial[ELAPSED_W-1:0];
        cell_next.quo = {din.quo[FRAC_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule
`default_nettype wire

// ===== hdl/lce_env_rom.sv =====
`default_nettype none
module lce_env_rom
    import lce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [ENV_AW-1:0] addr,
    output logic [FRAC_BITS:0]     data
);

    localparam env_tab_t ROM = env_table();

    logic [FRAC_BITS:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// ===== hdl/led_color_effect_generator_unit.sv =====
`default_nettype none
// LED effect generator: maps a cue's elapsed milliseconds to one linear RGB
// color for solid, fade, breathe or strobe modes (other modes give black).
// One request is taken every cycle while the output is not stalled; it passes
// through 32 remainder cells for elapsed mod period, 16 fraction cells for the
// fade or phase fraction, then envelope ROM, mix, brightness multiply and
// rounding stages. A result not taken stalls the whole pipe. Configuration
// registers are written through cfg_we/cfg_index/cfg_data and must only change
// while no request is in flight.
module led_color_effect_generator_unit
    import lce_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lce_in_if.sink                     req,
    lce_out_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int M_W = FRAC_BITS + 8;
    localparam int P_W = FRAC_BITS + 16;
    localparam logic [FRAC_BITS:0] ONE_V = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PHASE_BITS:0] PHASE_FULL = {1'b1, {PHASE_BITS{1'b0}}};
    localparam logic [PHASE_BITS:0] PHASE_HALF = {2'b01, {(PHASE_BITS-1){1'b0}}};
    localparam logic [P_W:0] ROUND_ADD = (P_W+1)'(255) << (FRAC_BITS - 1);

    typedef struct packed {
        logic                 valid;
        logic [FRAC_BITS:0]   f;
        logic                 strobe_on;
    } p1_t;

    logic [2:0]  effect_mode_reg;
    logic [23:0] color_a_reg;
    logic [23:0] color_b_reg;
    logic [7:0]  brightness_reg;
    logic [7:0]  period_low_reg;
    logic [7:0]  period_high_reg;
    logic [31:0] fade_duration_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg   <= MODE_SOLID;
            color_a_reg       <= '0;
            color_b_reg       <= '0;
            brightness_reg    <= 8'd255;
            period_low_reg    <= '0;
            period_high_reg   <= '0;
            fade_duration_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EFFECT_MODE:   effect_mode_reg   <= cfg_data[2:0];
                REG_COLOR_A:       color_a_reg       <= cfg_data[23:0];
                REG_COLOR_B:       color_b_reg       <= cfg_data[23:0];
                REG_BRIGHTNESS:    brightness_reg    <= cfg_data[7:0];
                REG_PERIOD_LOW:    period_low_reg    <= cfg_data[7:0];
                REG_PERIOD_HIGH:   period_high_reg   <= cfg_data[7:0];
                REG_FADE_DURATION: fade_duration_reg <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    // periods in ms
    logic [15:0] units;
    logic [15:0] units_eff;
    logic [7:0]  strobe_units;
    logic [19:0] breathe_p;
    logic [11:0] strobe_p;
    logic [ELAPSED_W-1:0] mod_div;
    logic [ELAPSED_W-1:0] frac_div;
    logic is_fade;

    always_comb
    begin
        units = {period_high_reg, period_low_reg};
        units_eff = (units == 16'd0) ? 16'd100 : units;
        strobe_units = (period_low_reg == 8'd0) ? 8'd100 : period_low_reg;
        breathe_p = {units_eff, 3'b000} + {3'b000, units_eff, 1'b0};
        strobe_p = {1'b0, strobe_units, 3'b000} + {3'b000, strobe_units, 1'b0};
        is_fade = effect_mode_reg == MODE_FADE;
        mod_div = (effect_mode_reg == MODE_BREATHE) ? ELAPSED_W'(breathe_p)
                                                     : ELAPSED_W'(strobe_p);
        frac_div = is_fade ? fade_duration_reg : mod_div;
    end

    logic  en;
    logic  out_valid_reg;
    cell_t chain [NUM_CELLS + 1];
    cell_t junction;

    assign en = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    always_comb
    begin
        chain[0] = '0;
        chain[0].valid = req.valid;
        chain[0].e = req.elapsed_ms;
    end

    always_comb
    begin
        junction = chain[MOD_CELLS];
        junction.strobe_on = (28'(chain[MOD_CELLS].rem[19:0]) * 28'd255)
                           < (28'(period_high_reg) * 28'(strobe_p));
        junction.rem = is_fade ? chain[MOD_CELLS].e : chain[MOD_CELLS].rem;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            if (gi < MOD_CELLS)
            begin : g_mod
                lce_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en),
                    .din       (chain[gi]),
                    .divisor   (mod_div),
                    .shift_bit (chain[gi].e[MOD_CELLS - 1 - gi]),
                    .dout      (chain[gi + 1])
                );
            end
            else
            begin : g_frac
                lce_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en),
                    .din       ((gi == MOD_CELLS) ? junction : chain[gi]),
                    .divisor   (frac_div),
                    .shift_bit (1'b0),
                    .dout      (chain[gi + 1])
                );
            end
        end
    endgenerate

    // phase fold and envelope lookup
    cell_t                tail;
    logic [PHASE_BITS:0]  k_ext;
    logic [ENV_AW-1:0]    kk;
    logic [FRAC_BITS:0]   env;
    logic                 fade_full;
    p1_t                  p1_reg;
    p1_t                  p1_next;

    assign tail = chain[NUM_CELLS];

    always_comb
    begin
        k_ext = {1'b0, tail.quo[FRAC_BITS-1 -: PHASE_BITS]};
        kk = (k_ext > PHASE_HALF) ? ENV_AW'(PHASE_FULL - k_ext) : k_ext[ENV_AW-1:0];
        fade_full = (fade_duration_reg == 32'd0) || (tail.e >= fade_duration_reg);
        p1_next.valid = tail.valid;
        p1_next.f = fade_full ? ONE_V : {1'b0, tail.quo};
        p1_next.strobe_on = tail.strobe_on;
    end

    lce_env_rom u_env_rom (
        .clk  (clk),
        .en   (en),
        .addr (kk),
        .data (env)
    );

    logic           p2_valid_reg;
    logic [M_W-1:0] mix_reg  [3];
    logic [M_W-1:0] mix_next [3];
    logic           p3_valid_reg;
    logic [P_W-1:0] prod_reg [3];
    logic [7:0]     chan_reg  [3];
    logic [7:0]     chan_next [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic [7:0]       ca;
            logic [7:0]       cb;
            logic [M_W:0]     pa;
            logic [M_W:0]     pb;
            ca = color_a_reg[23 - 8*ch -: 8];
            cb = color_b_reg[23 - 8*ch -: 8];
            pa = (M_W+1)'(ca) * (M_W+1)'(ONE_V - p1_reg.f);
            pb = (M_W+1)'(cb) * (M_W+1)'(p1_reg.f);
            case (effect_mode_reg)
                MODE_SOLID:   mix_next[ch] = {ca, {FRAC_BITS{1'b0}}};
                MODE_FADE:    mix_next[ch] = M_W'(pa + pb);
                MODE_BREATHE: mix_next[ch] = M_W'((M_W+1)'(ca) * (M_W+1)'(env));
                MODE_STROBE:  mix_next[ch] = p1_reg.strobe_on ? {ca, {FRAC_BITS{1'b0}}}
                                                              : '0;
                default:      mix_next[ch] = '0;
            endcase
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic [P_W:0]     n;
            logic [16:0]      x;
            logic [16:0]      y;
            n = (P_W+1)'(prod_reg[ch]) + ROUND_ADD;
            x = n[P_W -: 17];
            y = x + (x >> 8) + 17'd1;
            chan_next[ch] = (y[16:8] > 9'd255) ? 8'd255 : y[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg        <= '0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_reg        <= p1_next;
            p2_valid_reg  <= p1_reg.valid;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                mix_reg[ch]  <= mix_next[ch];
                prod_reg[ch] <= P_W'(mix_reg[ch]) * P_W'(brightness_reg);
                chan_reg[ch] <= chan_next[ch];
            end
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.red   = chan_reg[0];
    assign rsp.green = chan_reg[1];
    assign rsp.blue  = chan_reg[2];

    a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(chain[NUM_CELLS].valid) && $stable(p1_reg.valid))
        else $error("pipeline advanced while stalled");

    a_fade_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        p1_reg.valid |-> p1_reg.f <= ONE_V)
        else $error("fade fraction above one");

    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        p1_reg.valid |-> env <= ONE_V)
        else $error("envelope above one");

endmodule
`default_nettype wire
